[hw/rtl/ttip_pkg.sv]
// Shared types, constants and character helpers for the text-to-integer parser.
// Used by every module of the block; depends on nothing else.

package ttip_pkg;

  // Default widths and fixed payload widths.
  localparam int WORD_BITS_DEF  = 64;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CHAR_BITS      = 8;
  localparam int BASE_BITS      = 6;
  localparam int VALUE_BITS     = 64;
  localparam int CONSUMED_BITS  = 16;
  localparam int STATUS_BITS    = 2;

  // Configuration port geometry.
  localparam int PADDR_BITS     = 3;
  localparam int PDATA_BITS     = 32;

  // Register indexes, taken from the word address.
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic REG_SIGNED_MODE = 1'b1;

  // Radix values.
  localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] DIGIT_NONE = 6'd36;
  localparam logic [BASE_BITS-1:0] LETTER_OFS = 6'd10;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_BAD_BASE = 2'd2;

  // Character codes.
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;

  // One input item.
  typedef struct packed {
    logic [CHAR_BITS-1:0] character;
    logic                 start_req;
  } ttip_in_t;

  // One result item.
  typedef struct packed {
    logic [VALUE_BITS-1:0]    value;
    logic [CONSUMED_BITS-1:0] consumed;
    logic [STATUS_BITS-1:0]   status;
  } ttip_out_t;

  // Commands from the controller to the datapath for one accepted item.
  typedef struct packed {
    logic                 step;          // an item is accepted this cycle
    logic                 start;         // clear the parse state first
    logic                 neg_wr;        // a sign character was taken
    logic                 neg_val;
    logic [1:0]           pos_inc;       // characters to add to the position
    logic                 digits_set;
    logic                 accum;         // multiply-add the digit
    logic [BASE_BITS-1:0] base_val;      // radix in force for this item
    logic                 emit;          // produce a result
    logic                 emit_bad;      // result is the invalid base report
    logic                 emit_nocount;  // no digits: report zero consumed
  } ttip_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [BASE_BITS-1:0] base;
    logic                 digits;
  } ttip_stat_t;

  // Digit value of a character, or DIGIT_NONE when it is not a digit.
  function automatic logic [BASE_BITS-1:0] ttip_digit(input logic [CHAR_BITS-1:0] c);
    logic [BASE_BITS-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = BASE_BITS'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = BASE_BITS'(c - CH_LA) + LETTER_OFS;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = BASE_BITS'(c - CH_UA) + LETTER_OFS;
    end
    return d;
  endfunction

  // White space: space, tab, line feed, vertical tab, form feed, carriage return.
  function automatic logic ttip_is_space(input logic [CHAR_BITS-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

[hw/rtl/ttip_regs.sv]
// Configuration registers of the parser behind an APB-style port.
// Depends on ttip_pkg.

module ttip_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ttip_pkg::PADDR_BITS-1:0] paddr,
  input  logic [ttip_pkg::PDATA_BITS-1:0] pwdata,
  output logic [ttip_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready,
  output logic [ttip_pkg::BASE_BITS-1:0]  number_base,
  output logic                           signed_mode
);
  import ttip_pkg::*;

  logic reg_index;
  logic wr_en;

  // Word index and write strobe.
  assign reg_index = paddr[PADDR_BITS-1];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
      signed_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_NUMBER_BASE: number_base <= pwdata[BASE_BITS-1:0];
        REG_SIGNED_MODE: signed_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_index)
      REG_NUMBER_BASE: prdata = PDATA_BITS'(number_base);
      REG_SIGNED_MODE: prdata = PDATA_BITS'(signed_mode);
      default:         prdata = '0;
    endcase
  end

endmodule

[hw/rtl/ttip_ctrl.sv]
// Parse controller: tracks the phase of the current string and issues
// per-item commands to the datapath. Depends on ttip_pkg.

module ttip_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [ttip_pkg::CHAR_BITS-1:0] character,
  input  logic                           start_req,
  input  logic [ttip_pkg::BASE_BITS-1:0] number_base,
  input  ttip_pkg::ttip_stat_t           stat,
  output ttip_pkg::ttip_cmd_t            cmd
);
  import ttip_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_FIRST,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  phase_t               ph;
  logic [BASE_BITS-1:0] base_cur;
  logic [BASE_BITS-1:0] eb_eff;
  logic [BASE_BITS-1:0] digit;
  logic [1:0]           pos_inc;
  logic                 digits_cur;
  logic                 base_bad;
  logic                 first_path;
  logic                 zero_path;
  logic                 go_digits;
  logic                 is_sign;
  logic                 is_x;

  // Phase register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Decode one character against the current phase. A start request resets
  // the parse, so the start character is handled as the first one of the string.
  always_comb begin
    base_cur   = start_req ? number_base : stat.base;
    digits_cur = start_req ? 1'b0 : stat.digits;
    ph         = start_req ? PH_LEAD : phase;
    digit      = ttip_digit(character);
    base_bad   = (number_base == BASE_ONE) || (number_base > BASE_MAX);
    is_sign    = (character == CH_PLUS) || (character == CH_MINUS);
    is_x       = (character == CH_LX) || (character == CH_UX);
    eb_eff     = base_cur;
    phase_next = phase;
    cmd        = '0;
    pos_inc    = 2'd0;
    first_path = 1'b0;
    zero_path  = 1'b0;
    go_digits  = 1'b0;

    if (accept) begin
      cmd.step   = 1'b1;
      cmd.start  = start_req;
      phase_next = ph;
      if (start_req && base_bad) begin
        cmd.emit     = 1'b1;
        cmd.emit_bad = 1'b1;
        phase_next   = PH_DONE;
      end else begin
        unique case (ph)
          PH_LEAD: begin
            if (ttip_is_space(character)) begin
              pos_inc = 2'd1;
            end else if (is_sign) begin
              cmd.neg_wr  = 1'b1;
              cmd.neg_val = (character == CH_MINUS);
              pos_inc     = 2'd1;
              phase_next  = PH_FIRST;
            end else begin
              first_path = 1'b1;
            end
          end
          PH_FIRST:  first_path = 1'b1;
          PH_ZERO:   zero_path  = 1'b1;
          PH_XSEEN: begin
            if (digit < BASE_HEX) begin
              eb_eff    = BASE_HEX;
              pos_inc   = 2'd1;
              go_digits = 1'b1;
            end else begin
              // "0x" without a hex digit: the value is the zero already seen.
              cmd.emit   = 1'b1;
              phase_next = PH_DONE;
            end
          end
          PH_DIGITS: go_digits = 1'b1;
          default: ;
        endcase

        // First character after any sign: a leading zero may open a prefix.
        if (first_path) begin
          if ((base_cur == BASE_AUTO || base_cur == BASE_HEX) && character == CH_ZERO) begin
            cmd.digits_set = 1'b1;
            pos_inc        = 2'd1;
            phase_next     = PH_ZERO;
          end else begin
            if (base_cur == BASE_AUTO) begin
              eb_eff = BASE_DEC;
            end
            go_digits = 1'b1;
          end
        end

        // Character after a leading zero.
        if (zero_path) begin
          if (is_x) begin
            phase_next = PH_XSEEN;
          end else begin
            if (base_cur == BASE_AUTO) begin
              eb_eff = BASE_OCT;
            end
            go_digits = 1'b1;
          end
        end

        // Digit body: accumulate, or end the number.
        if (go_digits) begin
          if (digit < eb_eff) begin
            cmd.accum      = 1'b1;
            cmd.digits_set = 1'b1;
            pos_inc        = 2'(pos_inc + 2'd1);
            phase_next     = PH_DIGITS;
          end else begin
            cmd.emit         = 1'b1;
            cmd.emit_nocount = !digits_cur;
            phase_next       = PH_DONE;
          end
        end
      end
    end

    cmd.pos_inc  = pos_inc;
    cmd.base_val = eb_eff;
  end

endmodule

[hw/rtl/ttip_dp.sv]
// Parser datapath: accumulator with multiply-add and saturation, position
// counter, sign and radix state, result formatting and the output register.
// Depends on ttip_pkg.

module ttip_dp #(
  parameter int WORD_BITS  = ttip_pkg::WORD_BITS_DEF,
  parameter int COUNT_BITS = ttip_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ttip_pkg::CHAR_BITS-1:0] character,
  input  logic                           signed_mode,
  input  ttip_pkg::ttip_cmd_t            cmd,
  output ttip_pkg::ttip_stat_t           stat,
  input  logic                           result_stall,
  output logic                           result_valid,
  output ttip_pkg::ttip_out_t            result_item
);
  import ttip_pkg::*;

  localparam int PROD_BITS = WORD_BITS + BASE_BITS;

  logic [WORD_BITS-1:0]   acc;
  logic [WORD_BITS-1:0]   acc_cur;
  logic [WORD_BITS-1:0]   acc_next;
  logic [WORD_BITS-1:0]   max_pos;
  logic [WORD_BITS-1:0]   max_neg;
  logic [WORD_BITS-1:0]   negated;
  logic [WORD_BITS-1:0]   emit_value;
  logic [PROD_BITS-1:0]   prod;
  logic                   prod_over;
  logic [BASE_BITS-1:0]   digit;
  logic [BASE_BITS-1:0]   base;
  logic                   ovf;
  logic                   ovf_cur;
  logic                   ovf_next;
  logic                   neg;
  logic                   neg_cur;
  logic                   neg_next;
  logic                   digits;
  logic                   digits_cur;
  logic [COUNT_BITS-1:0]  pos;
  logic [COUNT_BITS-1:0]  pos_cur;
  logic [COUNT_BITS-1:0]  pos_next;
  logic [COUNT_BITS:0]    pos_sum;
  logic                   too_big;
  logic [STATUS_BITS-1:0] emit_status;
  logic [COUNT_BITS-1:0]  emit_count;

  assign stat.base   = base;
  assign stat.digits = digits;

  // State as seen by this item: a start clears it first.
  assign acc_cur    = cmd.start ? '0 : acc;
  assign ovf_cur    = cmd.start ? 1'b0 : ovf;
  assign neg_cur    = cmd.start ? 1'b0 : neg;
  assign digits_cur = cmd.start ? 1'b0 : digits;
  assign pos_cur    = cmd.start ? '0 : pos;

  // Multiply-add; anything above the word means the value no longer fits.
  assign digit     = ttip_digit(character);
  assign prod      = PROD_BITS'(acc_cur) * PROD_BITS'(cmd.base_val) + PROD_BITS'(digit);
  assign prod_over = |prod[PROD_BITS-1:WORD_BITS];

  // Next accumulator and flags.
  always_comb begin
    acc_next = acc_cur;
    if (cmd.accum) begin
      if (prod_over) begin
        acc_next = '1;
      end else if (!ovf_cur) begin
        acc_next = prod[WORD_BITS-1:0];
      end
    end
    ovf_next = ovf_cur || (cmd.accum && prod_over);
    neg_next = cmd.neg_wr ? cmd.neg_val : neg_cur;
  end

  // Saturating position count.
  assign pos_sum  = {1'b0, pos_cur} + (COUNT_BITS + 1)'(cmd.pos_inc);
  assign pos_next = pos_sum[COUNT_BITS] ? '1 : pos_sum[COUNT_BITS-1:0];

  // Result formatting: clamp in signed mode, wrap negation otherwise.
  assign max_pos = {1'b0, {(WORD_BITS-1){1'b1}}};
  assign max_neg = ~max_pos;
  assign negated = '0 - acc_cur;
  assign too_big = neg_cur ? (acc_cur[WORD_BITS-1] && (|acc_cur[WORD_BITS-2:0]))
                           : acc_cur[WORD_BITS-1];

  always_comb begin
    emit_status = ST_OK;
    emit_value  = neg_cur ? negated : acc_cur;
    emit_count  = cmd.emit_nocount ? '0 : pos_cur;
    if (cmd.emit_bad) begin
      emit_status = ST_BAD_BASE;
      emit_value  = '0;
      emit_count  = '0;
    end else if (signed_mode) begin
      if (ovf_cur || too_big) begin
        emit_status = ST_RANGE;
        emit_value  = neg_cur ? max_neg : max_pos;
      end
    end else if (ovf_cur) begin
      emit_status = ST_RANGE;
      emit_value  = '1;
    end
  end

  // Parse state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      ovf          <= 1'b0;
      neg          <= 1'b0;
      digits       <= 1'b0;
      pos          <= '0;
      base         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.step) begin
        acc    <= acc_next;
        ovf    <= ovf_next;
        neg    <= neg_next;
        digits <= digits_cur || cmd.digits_set;
        pos    <= pos_next;
        base   <= cmd.base_val;
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_item.value    <= VALUE_BITS'(emit_value);
      result_item.consumed <= CONSUMED_BITS'(emit_count);
      result_item.status   <= emit_status;
    end
  end

endmodule

[hw/rtl/text_to_integer_parser.sv]
// Top level of the streaming text-to-integer parser: configuration registers,
// parse controller and datapath. Depends on ttip_pkg, ttip_regs, ttip_ctrl, ttip_dp.
//
//   Channel  | Direction | Handshake              | Payload
//   ---------+-----------+------------------------+------------------------------
//   char     | in        | char_valid/char_stall  | char_item: character, start_req
//   result   | out       | result_valid/stall     | result_item: value, consumed, status
//   config   | in        | psel/penable/pready    | paddr, pwdata, prdata
//
// One character is taken per cycle unless stalled; each digit passes the datapath's
// WORD_BITS x 6 multiply-add and overflow check in the cycle it is accepted.
// A result is registered and shows in the cycle after the character that ends the number.
// The character channel stalls only while a result waits and the result side stalls.
// Synchronous reset sets the radix register to 10 and unsigned mode, and idles the parse.

module text_to_integer_parser #(
  parameter int WORD_BITS  = ttip_pkg::WORD_BITS_DEF,
  parameter int COUNT_BITS = ttip_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            char_valid,
  output logic                            char_stall,
  input  ttip_pkg::ttip_in_t              char_item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output ttip_pkg::ttip_out_t             result_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ttip_pkg::PADDR_BITS-1:0] paddr,
  input  logic [ttip_pkg::PDATA_BITS-1:0] pwdata,
  output logic [ttip_pkg::PDATA_BITS-1:0] prdata,
  output logic                            pready
);
  import ttip_pkg::*;

  logic [BASE_BITS-1:0] number_base;
  logic                 signed_mode;
  logic                 accept;
  ttip_cmd_t            cmd;
  ttip_stat_t           stat;

  // Hold off new items only while a finished result cannot leave.
  assign char_stall = result_valid && result_stall;
  assign accept     = char_valid && !char_stall;

  ttip_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .number_base (number_base),
    .signed_mode (signed_mode)
  );

  ttip_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .character   (char_item.character),
    .start_req   (char_item.start_req),
    .number_base (number_base),
    .stat        (stat),
    .cmd         (cmd)
  );

  ttip_dp #(
    .WORD_BITS  (WORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .character    (char_item.character),
    .signed_mode  (signed_mode),
    .cmd          (cmd),
    .stat         (stat),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_item  (result_item)
  );

endmodule

[hw/rtl/ttip_checker.sv]
// Port-level checks for the text-to-integer parser, bound to the top level.
// Depends on ttip_pkg and text_to_integer_parser.

module ttip_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_stall,
  input ttip_pkg::ttip_out_t result_item
);
  import ttip_pkg::*;

  // A waiting result stays offered while the receiver stalls.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_item))
    else $error("result payload changed while stalled");

  // The invalid base report carries neither value nor count.
  a_bad_base_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.status == ST_BAD_BASE |->
      result_item.value == '0 && result_item.consumed == '0)
    else $error("invalid base result is not empty");

  // With nothing consumed there is no value and no range report.
  a_no_digits_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.consumed == '0 |->
      result_item.value == '0 && result_item.status != ST_RANGE)
    else $error("result without digits carries a value");

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);
